/* rtl/mbls_pkg.sv */
// Shared constants, codes and helpers for the bounded multi-bucket list store.
`timescale 1ns / 1ps
`default_nettype none
package mbls_pkg;
	localparam int BUCKETS = 8;
	localparam int CAP     = 8;
	localparam int DEPTH   = BUCKETS * CAP;
	localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int IDX_W   = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int CNT_W   = $clog2(CAP + 1);
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TOT_W   = $clog2(DEPTH + 1);
	localparam int NC_W    = 10;
	localparam int WORD_W  = 32;

	typedef enum logic [3:0] {
		OP_CREATE      = 4'd0,
		OP_APPEND      = 4'd1,
		OP_POP         = 4'd2,
		OP_DELETE      = 4'd3,
		OP_RESIZE      = 4'd4,
		OP_COUNT       = 4'd5,
		OP_READ        = 4'd6,
		OP_READ_SORTED = 4'd7,
		OP_READ_ALL    = 4'd8,
		OP_ALL_SORTED  = 4'd9,
		OP_CLEAR       = 4'd10
	} op_t;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_BAD_BUCKET = 4'd1,
		ST_BAD_SIZE   = 4'd2,
		ST_EXISTS     = 4'd3,
		ST_NO_MEMORY  = 4'd4,
		ST_NO_BUCKET  = 4'd5,
		ST_FULL       = 4'd6,
		ST_EMPTY      = 4'd7,
		ST_NOT_FOUND  = 4'd8,
		ST_BAD_NEW    = 4'd9,
		ST_ALL_EMPTY  = 4'd10
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_DEL_RD,
		S_DEL_CMP,
		S_SH_RD,
		S_SH_WR,
		S_FIN,
		S_RD_RD,
		S_RD_EMIT,
		S_SC_RD,
		S_SC_CMP,
		S_SC_EMIT
	} state_t;

	function automatic logic [ADDR_W-1:0] addr_of(input logic [BKT_W-1:0] b,
		input logic [IDX_W-1:0] i);
		addr_of = ADDR_W'(int'(b) * CAP + int'(i));
	endfunction
endpackage
`default_nettype wire

/* rtl/mbls_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module mbls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* rtl/multi_bucket_bounded_list_store_core.sv */
// Top level of the bounded multi-bucket list store with its sequencer.
// Simple opcodes are executed in S_EXEC once the output register is free; their
// result is registered, and s_tready is high again in the cycle it appears.
// Unsorted reads pass S_RD_RD and S_RD_EMIT per element; a delete reads and
// compares each word, then shifts the rest down. Sorted reads run one selection
// pass over the elements, through the single RAM read port, per element emitted.
// One item at a time; reset (arst_n low) clears all bucket state at once.
`timescale 1ns / 1ps
`default_nettype none
module multi_bucket_bounded_list_store_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// opcode[3:0], bucket[7:4], value[39:8], size_or_delta[47:40]
	input  wire logic [47:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status[3:0], data_value[35:4], element_count[39:36]
	output logic [39:0]      m_tdata,
	// data_valid[0]
	output logic             m_tuser,
	output logic             m_tlast
);
	localparam int BKT_W  = mbls_pkg::BKT_W;
	localparam int IDX_W  = mbls_pkg::IDX_W;
	localparam int CNT_W  = mbls_pkg::CNT_W;
	localparam int ADDR_W = mbls_pkg::ADDR_W;
	localparam int TOT_W  = mbls_pkg::TOT_W;
	localparam int NC_W   = mbls_pkg::NC_W;

	mbls_pkg::state_t state_q, state_d;

	// Per-bucket bookkeeping, cleared at reset.
	logic             exists_q [mbls_pkg::BUCKETS];
	logic [CNT_W-1:0] cap_q    [mbls_pkg::BUCKETS];
	logic [CNT_W-1:0] fill_q   [mbls_pkg::BUCKETS];

	// Captured item.
	mbls_pkg::op_t      op_q;
	logic [3:0]         bk_q;
	logic [31:0]        val_q;
	logic signed [7:0]  sd_q;

	// Walk position, sorted selection state and deferred status.
	logic [BKT_W-1:0]   cur_b_q;
	logic [IDX_W-1:0]   cur_i_q;
	logic [TOT_W-1:0]   k_q;
	logic [31:0]        prev_v_q, best_v_q;
	logic [ADDR_W-1:0]  prev_p_q, best_p_q;
	logic               have_prev_q, have_best_q;
	mbls_pkg::status_t  fin_st_q;

	// Output register.
	logic               out_valid_q;
	mbls_pkg::status_t  out_st_q;
	logic [31:0]        out_data_q;
	logic               out_dv_q;
	logic [3:0]         out_cnt_q;
	logic               out_last_q;

	logic               out_free;
	logic               out_load;
	mbls_pkg::status_t  o_st;
	logic [31:0]        o_data;
	logic               o_dv;
	logic [3:0]         o_cnt;
	logic               o_last;

	// RAM ports.
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [31:0]        ram_wdata, ram_rdata;

	// Decoded helpers.
	logic               all_q;
	logic               bk_ok;
	logic [BKT_W-1:0]   b_q;
	logic               b_exists;
	logic [CNT_W-1:0]   b_fill, b_cap;
	logic               full;
	logic signed [NC_W-1:0] nc;
	logic               nc_low, nc_high;
	mbls_pkg::status_t  cr_st, rs_st;
	logic               nb_found, fb_found;
	logic [BKT_W-1:0]   nb, fb;
	logic               i_more;
	logic               nxt_ok;
	logic [BKT_W-1:0]   nxt_b;
	logic [IDX_W-1:0]   nxt_i;
	logic [TOT_W-1:0]   tot_all, n_tot;
	logic               match;
	logic               gt_prev, lt_best, take;
	logic               sc_last;
	logic               fill_ok;

	assign all_q    = (op_q == mbls_pkg::OP_READ_ALL) || (op_q == mbls_pkg::OP_ALL_SORTED);
	assign bk_ok    = (int'(bk_q) >= 1) && (int'(bk_q) <= mbls_pkg::BUCKETS);
	assign b_q      = BKT_W'(bk_q - 4'd1);
	assign b_exists = exists_q[b_q];
	assign b_fill   = fill_q[b_q];
	assign b_cap    = cap_q[b_q];
	assign full     = (b_fill >= b_cap) || (b_fill >= CNT_W'(mbls_pkg::CAP));

	// Create checks run in the order: bad size, exists, no memory.
	always_comb begin
		if (int'(sd_q) < 1) begin
			cr_st = mbls_pkg::ST_BAD_SIZE;
		end else if (b_exists) begin
			cr_st = mbls_pkg::ST_EXISTS;
		end else if (int'(sd_q) > mbls_pkg::CAP) begin
			cr_st = mbls_pkg::ST_NO_MEMORY;
		end else begin
			cr_st = mbls_pkg::ST_OK;
		end
	end

	// Resize: new capacity is the current one plus a signed delta.
	assign nc      = $signed(NC_W'({1'b0, b_cap})) + NC_W'(sd_q);
	assign nc_low  = nc[NC_W-1] || (nc == '0);
	assign nc_high = !nc[NC_W-1] && ($unsigned(nc) > NC_W'(mbls_pkg::CAP));
	assign rs_st   = nc_low ? mbls_pkg::ST_BAD_NEW :
		(nc_high ? mbls_pkg::ST_NO_MEMORY : mbls_pkg::ST_OK);

	// Next non-empty bucket after the current one, and the first non-empty one.
	always_comb begin
		nb_found = 1'b0;
		nb       = '0;
		fb_found = 1'b0;
		fb       = '0;
		for (int bb = mbls_pkg::BUCKETS - 1; bb >= 0; bb--) begin
			if (exists_q[bb] && (fill_q[bb] != '0)) begin
				if (bb > int'(cur_b_q)) begin
					nb_found = 1'b1;
					nb       = BKT_W'(bb);
				end
				fb_found = 1'b1;
				fb       = BKT_W'(bb);
			end
		end
	end

	assign i_more = (CNT_W'(cur_i_q) + CNT_W'(1)) < fill_q[cur_b_q];
	assign nxt_ok = i_more || (all_q && nb_found);
	assign nxt_b  = i_more ? cur_b_q : nb;
	assign nxt_i  = i_more ? (cur_i_q + IDX_W'(1)) : '0;

	// Total number of elements seen by the current read.
	always_comb begin
		tot_all = '0;
		for (int bb = 0; bb < mbls_pkg::BUCKETS; bb++) begin
			if (exists_q[bb]) begin
				tot_all = tot_all + TOT_W'(fill_q[bb]);
			end
		end
	end
	assign n_tot = all_q ? tot_all : TOT_W'(b_fill);

	// The delete search compares each word for equality, and the selection pass
	// keeps its running minimum with a separate signed comparison.
	assign match   = (ram_rdata == val_q);
	assign lt_best = !have_best_q || ($signed(ram_rdata) < $signed(best_v_q));
	// Ties are broken by store position, which the walk visits in increasing order.
	assign gt_prev = !have_prev_q || ($signed(ram_rdata) > $signed(prev_v_q)) ||
		((ram_rdata == prev_v_q) && (ram_raddr > prev_p_q));
	assign take    = gt_prev && lt_best;
	assign sc_last = (k_q + TOT_W'(1)) == n_tot;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == mbls_pkg::S_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mbls_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = mbls_pkg::S_EXEC;
				end
			end
			mbls_pkg::S_EXEC: begin
				if (out_free) begin
					state_d = mbls_pkg::S_IDLE;
					if (all_q) begin
						if (n_tot != '0) begin
							state_d = (op_q == mbls_pkg::OP_READ_ALL) ?
								mbls_pkg::S_RD_RD : mbls_pkg::S_SC_RD;
						end
					end else if (op_q < mbls_pkg::OP_CLEAR && bk_ok &&
						op_q != mbls_pkg::OP_CREATE && b_exists && b_fill != '0) begin
						if (op_q == mbls_pkg::OP_DELETE) begin
							state_d = mbls_pkg::S_DEL_RD;
						end else if (op_q == mbls_pkg::OP_READ) begin
							state_d = mbls_pkg::S_RD_RD;
						end else if (op_q == mbls_pkg::OP_READ_SORTED) begin
							state_d = mbls_pkg::S_SC_RD;
						end
					end
				end
			end
			mbls_pkg::S_DEL_RD:  state_d = mbls_pkg::S_DEL_CMP;
			mbls_pkg::S_DEL_CMP: begin
				if (match) begin
					state_d = i_more ? mbls_pkg::S_SH_RD : mbls_pkg::S_FIN;
				end else begin
					state_d = i_more ? mbls_pkg::S_DEL_RD : mbls_pkg::S_FIN;
				end
			end
			mbls_pkg::S_SH_RD:   state_d = mbls_pkg::S_SH_WR;
			mbls_pkg::S_SH_WR:   state_d = i_more ? mbls_pkg::S_SH_RD : mbls_pkg::S_FIN;
			mbls_pkg::S_FIN: begin
				if (out_free) begin
					state_d = mbls_pkg::S_IDLE;
				end
			end
			mbls_pkg::S_RD_RD:   state_d = mbls_pkg::S_RD_EMIT;
			mbls_pkg::S_RD_EMIT: begin
				if (out_free) begin
					state_d = nxt_ok ? mbls_pkg::S_RD_RD : mbls_pkg::S_IDLE;
				end
			end
			mbls_pkg::S_SC_RD:   state_d = mbls_pkg::S_SC_CMP;
			mbls_pkg::S_SC_CMP:  state_d = nxt_ok ? mbls_pkg::S_SC_RD : mbls_pkg::S_SC_EMIT;
			mbls_pkg::S_SC_EMIT: begin
				if (out_free) begin
					state_d = sc_last ? mbls_pkg::S_IDLE : mbls_pkg::S_SC_RD;
				end
			end
			default: state_d = mbls_pkg::S_IDLE;
		endcase
	end

	// Result loading and RAM control.
	always_comb begin
		out_load  = 1'b0;
		o_st      = mbls_pkg::ST_OK;
		o_data    = '0;
		o_dv      = 1'b0;
		o_cnt     = '0;
		o_last    = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = mbls_pkg::addr_of(b_q, IDX_W'(b_fill));
		ram_wdata = val_q;
		ram_raddr = mbls_pkg::addr_of(cur_b_q, cur_i_q);
		case (state_q)
			mbls_pkg::S_EXEC: begin
				if (out_free) begin
					if (all_q) begin
						out_load = (n_tot == '0);
						o_st     = mbls_pkg::ST_ALL_EMPTY;
					end else if (op_q >= mbls_pkg::OP_CLEAR) begin
						out_load = 1'b1;
					end else if (!bk_ok) begin
						out_load = 1'b1;
						o_st     = mbls_pkg::ST_BAD_BUCKET;
					end else if (op_q == mbls_pkg::OP_CREATE) begin
						out_load = 1'b1;
						o_st     = cr_st;
					end else if (!b_exists) begin
						out_load = 1'b1;
						o_st     = mbls_pkg::ST_NO_BUCKET;
					end else begin
						case (op_q)
							mbls_pkg::OP_APPEND: begin
								out_load = 1'b1;
								o_st     = full ? mbls_pkg::ST_FULL : mbls_pkg::ST_OK;
								ram_we   = !full;
							end
							mbls_pkg::OP_POP, mbls_pkg::OP_DELETE: begin
								out_load = (b_fill == '0) || (op_q == mbls_pkg::OP_POP);
								o_st     = (b_fill == '0) ? mbls_pkg::ST_EMPTY : mbls_pkg::ST_OK;
							end
							mbls_pkg::OP_RESIZE: begin
								out_load = 1'b1;
								o_st     = rs_st;
							end
							mbls_pkg::OP_COUNT: begin
								out_load = 1'b1;
								o_cnt    = 4'(b_fill);
							end
							default: begin
								out_load = (b_fill == '0);
							end
						endcase
					end
				end
			end
			mbls_pkg::S_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = mbls_pkg::addr_of(cur_b_q, cur_i_q - IDX_W'(1));
				ram_wdata = ram_rdata;
			end
			mbls_pkg::S_FIN: begin
				out_load = out_free;
				o_st     = fin_st_q;
			end
			mbls_pkg::S_RD_EMIT: begin
				out_load = out_free;
				o_data   = ram_rdata;
				o_dv     = 1'b1;
				o_last   = !nxt_ok;
			end
			mbls_pkg::S_SC_EMIT: begin
				out_load = out_free;
				o_data   = best_v_q;
				o_dv     = 1'b1;
				o_last   = sc_last;
			end
			default: begin
			end
		endcase
	end

	mbls_ram #(
		.WIDTH(mbls_pkg::WORD_W),
		.DEPTH(mbls_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control state and bucket bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mbls_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			for (int bb = 0; bb < mbls_pkg::BUCKETS; bb++) begin
				exists_q[bb] <= 1'b0;
				cap_q[bb]    <= '0;
				fill_q[bb]   <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == mbls_pkg::S_EXEC && out_free && !all_q) begin
				if (op_q == mbls_pkg::OP_CLEAR) begin
					for (int bb = 0; bb < mbls_pkg::BUCKETS; bb++) begin
						exists_q[bb] <= 1'b0;
						cap_q[bb]    <= '0;
						fill_q[bb]   <= '0;
					end
				end else if (op_q < mbls_pkg::OP_CLEAR && bk_ok) begin
					if (op_q == mbls_pkg::OP_CREATE) begin
						if (cr_st == mbls_pkg::ST_OK) begin
							exists_q[b_q] <= 1'b1;
							cap_q[b_q]    <= CNT_W'(sd_q);
							fill_q[b_q]   <= '0;
						end
					end else if (b_exists) begin
						case (op_q)
							mbls_pkg::OP_APPEND: begin
								if (!full) begin
									fill_q[b_q] <= b_fill + CNT_W'(1);
								end
							end
							mbls_pkg::OP_POP: begin
								if (b_fill != '0) begin
									fill_q[b_q] <= b_fill - CNT_W'(1);
								end
							end
							mbls_pkg::OP_RESIZE: begin
								if (rs_st == mbls_pkg::ST_OK) begin
									cap_q[b_q] <= CNT_W'(nc);
									if (b_fill > CNT_W'(nc)) begin
										fill_q[b_q] <= CNT_W'(nc);
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			// A delete that found its word shortens the list when the shift ends.
			if ((state_q == mbls_pkg::S_DEL_CMP && match && !i_more) ||
				(state_q == mbls_pkg::S_SH_WR && !i_more)) begin
				fill_q[cur_b_q] <= fill_q[cur_b_q] - CNT_W'(1);
			end
		end
	end

	// Item capture, walk position, selection and result payload.
	always_ff @(posedge clk) begin
		if (state_q == mbls_pkg::S_IDLE && s_tvalid) begin
			op_q  <= mbls_pkg::op_t'(s_tdata[3:0]);
			bk_q  <= s_tdata[7:4];
			val_q <= s_tdata[39:8];
			sd_q  <= $signed(s_tdata[47:40]);
		end
		case (state_q)
			mbls_pkg::S_EXEC: begin
				cur_b_q     <= all_q ? fb : b_q;
				cur_i_q     <= '0;
				k_q         <= '0;
				have_prev_q <= 1'b0;
				have_best_q <= 1'b0;
			end
			mbls_pkg::S_DEL_CMP: begin
				fin_st_q <= match ? mbls_pkg::ST_OK : mbls_pkg::ST_NOT_FOUND;
				if (i_more) begin
					cur_i_q <= cur_i_q + IDX_W'(1);
				end
			end
			mbls_pkg::S_SH_WR: begin
				fin_st_q <= mbls_pkg::ST_OK;
				if (i_more) begin
					cur_i_q <= cur_i_q + IDX_W'(1);
				end
			end
			mbls_pkg::S_RD_EMIT: begin
				if (out_free && nxt_ok) begin
					cur_b_q <= nxt_b;
					cur_i_q <= nxt_i;
				end
			end
			mbls_pkg::S_SC_CMP: begin
				if (take) begin
					best_v_q    <= ram_rdata;
					best_p_q    <= ram_raddr;
					have_best_q <= 1'b1;
				end
				if (nxt_ok) begin
					cur_b_q <= nxt_b;
					cur_i_q <= nxt_i;
				end
			end
			mbls_pkg::S_SC_EMIT: begin
				if (out_free) begin
					prev_v_q    <= best_v_q;
					prev_p_q    <= best_p_q;
					have_prev_q <= 1'b1;
					have_best_q <= 1'b0;
					k_q         <= k_q + TOT_W'(1);
					cur_b_q     <= all_q ? fb : b_q;
					cur_i_q     <= '0;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_st_q   <= o_st;
			out_data_q <= o_data;
			out_dv_q   <= o_dv;
			out_cnt_q  <= o_cnt;
			out_last_q <= o_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_cnt_q, out_data_q, out_st_q};
	assign m_tuser  = out_dv_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		fill_ok = 1'b1;
		for (int bb = 0; bb < mbls_pkg::BUCKETS; bb++) begin
			if (fill_q[bb] > cap_q[bb]) begin
				fill_ok = 1'b0;
			end
		end
	end

	// No bucket ever holds more words than its capacity.
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n) fill_ok)
		else $error("bucket fill exceeds capacity");

	// A result without an element is always the only result of its item.
	a_nodata_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tlast)
		else $error("status-only result not marked last");

	// The sorted readout never emits more elements than are stored.
	a_sort_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mbls_pkg::S_SC_EMIT) |-> (k_q < n_tot))
		else $error("sorted readout overran element count");
endmodule
`default_nettype wire

/* tb/mbls_checker.sv */
// Checker for the bounded multi-bucket list store: mirrors its state and compares every result.
`timescale 1ns / 1ps
module mbls_checker
	import mbls_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [47:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [39:0] m_tdata,
	input  wire logic        m_tuser,
	input  wire logic        m_tlast,
	output int               fail_count,
	output int               pending_results,
	output int               results_seen
);
	typedef struct packed {
		status_t     status;
		logic [31:0] word;
		logic        has_word;
		logic [3:0]  count;
		logic        last;
	} store_result_t;

	logic        mirror_exists [BUCKETS];
	int          mirror_cap    [BUCKETS];
	int          mirror_fill   [BUCKETS];
	logic [31:0] mirror_words  [BUCKETS][CAP];
	store_result_t expected_results[$];

	// Queues a single status-only result, such as that of a non-read command.
	function automatic void push_single(status_t st, logic [3:0] cnt);
		store_result_t r;
		r = '{status: st, word: '0, has_word: 1'b0, count: cnt, last: 1'b1};
		expected_results.push_back(r);
	endfunction

	// Queues a readout list, sorted if asked; empty lists give one result with empty_st.
	function automatic void push_words(logic [31:0] w[$], bit sorted, status_t empty_st);
		store_result_t r;
		logic [31:0] t;
		if (sorted) begin
			for (int i = 1; i < w.size(); i++)
				for (int j = i; j > 0 && $signed(w[j]) < $signed(w[j-1]); j--) begin
					t = w[j]; w[j] = w[j-1]; w[j-1] = t;
				end
		end
		if (w.size() == 0) begin
			push_single(empty_st, 4'd0);
			return;
		end
		foreach (w[i]) begin
			r = '{status: ST_OK, word: w[i], has_word: 1'b1, count: 4'd0,
				last: (i == w.size() - 1)};
			expected_results.push_back(r);
		end
	endfunction

	function automatic void predict_command(logic [47:0] item);
		logic [3:0]  op;
		logic [3:0]  bk;
		logic [31:0] val;
		int          sd, b, fill, pos, nc;
		logic [31:0] w[$];
		op  = item[3:0];
		bk  = item[7:4];
		val = item[39:8];
		sd  = $signed(item[47:40]);
		if (op == OP_READ_ALL || op == OP_ALL_SORTED) begin
			for (int k = 0; k < BUCKETS; k++)
				if (mirror_exists[k])
					for (int i = 0; i < mirror_fill[k]; i++) w.push_back(mirror_words[k][i]);
			push_words(w, op == OP_ALL_SORTED, ST_ALL_EMPTY);
			return;
		end
		if (op == OP_CLEAR) begin
			for (int k = 0; k < BUCKETS; k++) begin
				mirror_exists[k] = 0; mirror_cap[k] = 0; mirror_fill[k] = 0;
			end
			push_single(ST_OK, 4'd0);
			return;
		end
		if (op > OP_CLEAR) begin
			push_single(ST_OK, 4'd0);
			return;
		end
		if (bk < 1 || bk > BUCKETS) begin
			push_single(ST_BAD_BUCKET, 4'd0);
			return;
		end
		b = bk - 1;
		if (op == OP_CREATE) begin
			if (sd < 1) push_single(ST_BAD_SIZE, 4'd0);
			else if (mirror_exists[b]) push_single(ST_EXISTS, 4'd0);
			else if (sd > CAP) push_single(ST_NO_MEMORY, 4'd0);
			else begin
				mirror_exists[b] = 1; mirror_cap[b] = sd; mirror_fill[b] = 0;
				push_single(ST_OK, 4'd0);
			end
			return;
		end
		if (!mirror_exists[b]) begin
			push_single(ST_NO_BUCKET, 4'd0);
			return;
		end
		fill = mirror_fill[b];
		case (op)
			OP_APPEND: begin
				if (fill >= mirror_cap[b] || fill >= CAP) push_single(ST_FULL, 4'd0);
				else begin
					mirror_words[b][fill] = val;
					mirror_fill[b] = fill + 1;
					push_single(ST_OK, 4'd0);
				end
			end
			OP_POP: begin
				if (fill == 0) push_single(ST_EMPTY, 4'd0);
				else begin
					mirror_fill[b] = fill - 1;
					push_single(ST_OK, 4'd0);
				end
			end
			OP_DELETE: begin
				pos = -1;
				for (int i = 0; i < fill; i++)
					if (pos < 0 && mirror_words[b][i] == val) pos = i;
				if (fill == 0) push_single(ST_EMPTY, 4'd0);
				else if (pos < 0) push_single(ST_NOT_FOUND, 4'd0);
				else begin
					for (int j = pos; j < fill - 1; j++) mirror_words[b][j] = mirror_words[b][j+1];
					mirror_fill[b] = fill - 1;
					push_single(ST_OK, 4'd0);
				end
			end
			OP_RESIZE: begin
				nc = mirror_cap[b] + sd;
				if (nc < 1) push_single(ST_BAD_NEW, 4'd0);
				else if (nc > CAP) push_single(ST_NO_MEMORY, 4'd0);
				else begin
					mirror_cap[b] = nc;
					if (fill > nc) mirror_fill[b] = nc;
					push_single(ST_OK, 4'd0);
				end
			end
			OP_COUNT: push_single(ST_OK, 4'(fill));
			default: begin
				for (int i = 0; i < fill; i++) w.push_back(mirror_words[b][i]);
				push_words(w, op == OP_READ_SORTED, ST_OK);
			end
		endcase
	endfunction

	assign pending_results = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		store_result_t e;
		if (!arst_n) begin
			for (int k = 0; k < BUCKETS; k++) begin
				mirror_exists[k] = 0; mirror_cap[k] = 0; mirror_fill[k] = 0;
			end
			expected_results.delete();
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			// The result side is checked before the command side so that a command
			// taken at this edge cannot be matched against a result already on the bus.
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("unexpected result %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_results.pop_front();
					if (m_tdata[3:0] != e.status
						|| m_tdata[35:4] != e.word
						|| m_tuser != e.has_word
						|| m_tdata[39:36] != e.count
						|| m_tlast != e.last)
						fail_count <= fail_count + 1;
					if (m_tdata[3:0] != e.status)
						$error("status: expected %0d, got %0d", e.status, m_tdata[3:0]);
					if (m_tdata[35:4] != e.word)
						$error("data_value: expected %h, got %h", e.word, m_tdata[35:4]);
					if (m_tuser != e.has_word)
						$error("data_valid: expected %b, got %b", e.has_word, m_tuser);
					if (m_tdata[39:36] != e.count)
						$error("element_count: expected %0d, got %0d", e.count,
							m_tdata[39:36]);
					if (m_tlast != e.last)
						$error("last: expected %b, got %b", e.last, m_tlast);
				end
			end
			if (s_tvalid && s_tready)
				predict_command(s_tdata);
		end
	end
endmodule

/* tb/tb_multi_bucket_bounded_list_store_core.sv */
// Testbench top for the bounded multi-bucket list store: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_multi_bucket_bounded_list_store_core;
	import mbls_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	int          fail_count;
	int          pending_results;
	int          results_seen;
	int          commands_sent;

	// A small pool of words makes deletes hit and sorted reads see duplicates.
	logic [31:0] word_pool[8];

	multi_bucket_bounded_list_store_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	mbls_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.fail_count      (fail_count),
		.pending_results (pending_results),
		.results_seen    (results_seen)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The receiver stalls in its own pattern: calm stretches alternate with
	// stretches in which tready drops at random.
	initial begin
		int phase;
		m_tready = 1'b0;
		phase = 0;
		forever begin
			@(posedge clk);
			phase++;
			if ((phase / 64) % 3 == 0)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// Sends one command and holds it until the block takes it. The valid stays
	// high across back-to-back commands; gaps come from the burst logic below.
	task automatic send_command(op_t op, logic [3:0] bk, logic [31:0] val, logic [7:0] sd);
		s_tvalid <= 1'b1;
		s_tdata  <= {sd, val, bk, 4'(op)};
		do @(posedge clk); while (!s_tready);
		commands_sent++;
	endtask

	task automatic send_raw(logic [47:0] item);
		s_tvalid <= 1'b1;
		s_tdata  <= item;
		do @(posedge clk); while (!s_tready);
		commands_sent++;
	endtask

	// Drops valid for a random gap after a burst of random length.
	int burst_left;
	task automatic maybe_gap();
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
		burst_left = $urandom_range(0, 8);
	endtask

	// Random command biased toward well-formed sequences on valid buckets.
	task automatic send_random_command();
		int  pick;
		op_t op;
		logic [3:0] bk;
		logic [7:0] sd;
		logic [31:0] val;
		pick = $urandom_range(0, 99);
		if (pick < 30) op = OP_APPEND;
		else if (pick < 38) op = OP_CREATE;
		else if (pick < 45) op = OP_DELETE;
		else if (pick < 51) op = OP_POP;
		else if (pick < 57) op = OP_RESIZE;
		else if (pick < 62) op = OP_COUNT;
		else if (pick < 70) op = OP_READ;
		else if (pick < 77) op = OP_READ_SORTED;
		else if (pick < 83) op = OP_READ_ALL;
		else if (pick < 89) op = OP_ALL_SORTED;
		else if (pick < 91) op = OP_CLEAR;
		else op = op_t'($urandom_range(0, 15));
		bk = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(1, BUCKETS));
		if (op == OP_CREATE)
			sd = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(1, CAP));
		else if (op == OP_RESIZE)
			sd = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8) - 4);
		else
			sd = 8'($urandom);
		val = ($urandom_range(0, 3) == 0) ? $urandom : word_pool[$urandom_range(0, 7)];
		send_command(op, bk, val, sd);
	endtask

	initial begin
		int drain;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		commands_sent = 0;
		burst_left    = 0;
		word_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
			32'h5, 32'h5, 32'hdead_beef, 32'h1234_5678};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty store, bad buckets, create checks, full and empty
		// buckets, delete hit and miss, resize limits, reads and clear.
		send_command(OP_READ_ALL, 4'd1, '0, '0);
		send_command(OP_APPEND, 4'd0, '0, '0);
		send_command(OP_COUNT, 4'd15, '0, '0);
		send_command(OP_APPEND, 4'd2, 32'h1, '0);
		send_command(OP_CREATE, 4'd1, '0, 8'h80);
		send_command(OP_CREATE, 4'd1, '0, 8'd9);
		send_command(OP_CREATE, 4'd1, '0, 8'd2);
		send_command(OP_CREATE, 4'd1, '0, 8'd3);
		send_command(OP_CREATE, 4'd8, '0, 8'd8);
		send_command(OP_READ, 4'd1, '0, '0);
		send_command(OP_POP, 4'd1, '0, '0);
		send_command(OP_DELETE, 4'd1, '0, '0);
		send_command(OP_APPEND, 4'd1, 32'h7fff_ffff, 8'hff);
		send_command(OP_APPEND, 4'd1, 32'h8000_0000, '0);
		send_command(OP_APPEND, 4'd1, 32'h0, '0);
		send_command(OP_APPEND, 4'd8, 32'hffff_ffff, '0);
		send_command(OP_DELETE, 4'd1, 32'h3, '0);
		send_command(OP_READ_SORTED, 4'd1, '0, '0);
		send_command(OP_RESIZE, 4'd1, '0, 8'h7f);
		send_command(OP_RESIZE, 4'd1, '0, 8'hfe);
		send_command(OP_RESIZE, 4'd1, '0, 8'h06);
		send_command(OP_COUNT, 4'd1, '0, '0);
		send_command(OP_ALL_SORTED, '0, '0, '0);
		send_command(OP_DELETE, 4'd1, 32'h7fff_ffff, '0);
		send_raw(48'hffff_ffff_ffff);
		send_command(OP_CLEAR, 4'd3, 32'hffff_ffff, 8'hff);

		// Random part in bursts with gaps.
		repeat (40) begin
			maybe_gap();
			send_random_command();
		end
		// Start from an empty store, fill half the buckets to their limit and
		// read them, sorted and not.
		send_command(OP_CLEAR, '0, '0, '0);
		for (int k = 1; k <= BUCKETS / 2; k++) begin
			send_command(OP_CREATE, 4'(k), '0, 8'(CAP));
			repeat (CAP) send_command(OP_APPEND, 4'(k), $urandom, '0);
		end
		send_command(OP_READ_SORTED, 4'(BUCKETS / 2), '0, '0);
		send_command(OP_READ_ALL, '0, '0, '0);
		send_command(OP_ALL_SORTED, '0, '0, '0);
		s_tvalid <= 1'b0;

		drain = 0;
		while (pending_results != 0 && drain < 200000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		$display("Sent %0d commands and checked %0d results, including sorted reads of full buckets.",
			commands_sent, results_seen);
		if (fail_count == 0 && pending_results == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: the largest directed read is a sorted read of 32 words, and
	// 20 ms is many times the slowest run.
	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end
endmodule
